// File: rtl/pfenc_pkg.sv
// Shared types, constants and helper functions for the Playfair digraph encryptor.
`timescale 1ns / 1ps

package pfenc_pkg;

    // Alphabet and square geometry
    localparam int SIDE    = 5;
    localparam int CELLS   = 25;
    localparam int LETTERS = 26;

    localparam logic [4:0] LETTER_I = 5'd8;
    localparam logic [4:0] LETTER_J = 5'd9;

    // Item kinds carried on the input tuser
    localparam logic [1:0] KIND_KEY  = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_PAIR = 2'd2;
    localparam logic [1:0] KIND_NONE = 2'd3;

    // Result status codes
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef logic [4:0] t_letter;
    typedef logic [4:0] t_cell;
    typedef logic [2:0] t_rc;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic key_place;
        logic fill_start;
        logic fill_step;
        logic pair_read;
        logic sq_read;
        logic load_out;
        logic set_complete;
    } t_cmd;

    // Status from the datapath back to the controller
    typedef struct packed {
        logic complete;
        logic fill_last;
        logic out_free;
    } t_stat;

    // j shares a cell with i
    function automatic t_letter fold_letter(input t_letter l);
        return (l == LETTER_J) ? LETTER_I : l;
    endfunction

    // row of a cell index below 25
    function automatic t_rc pos_row(input t_cell p);
        t_rc r;
        if (p >= 5'd20)      r = 3'd4;
        else if (p >= 5'd15) r = 3'd3;
        else if (p >= 5'd10) r = 3'd2;
        else if (p >= 5'd5)  r = 3'd1;
        else                 r = 3'd0;
        return r;
    endfunction

    // row * 5 + col
    function automatic t_cell rc_index(input t_rc r, input t_rc c);
        return {r[2:0], 2'b00} + {2'b00, r} + {2'b00, c};
    endfunction

    // column of a cell index below 25
    function automatic t_rc pos_col(input t_cell p);
        t_cell d;
        d = p - rc_index(pos_row(p), 3'd0);
        return d[2:0];
    endfunction

    // step right or down with wrap
    function automatic t_rc next_rc(input t_rc v);
        return (v == 3'(SIDE - 1)) ? 3'd0 : 3'(v + 3'd1);
    endfunction

endpackage

// File: rtl/playfair_digraph_encrypt.sv
// Top level of the Playfair digraph encryptor: stream ports, controller and datapath.
`timescale 1ns / 1ps
//
// Channel  | Dir | Handshake                   | Payload
// s_axis   | in  | s_axis_tvalid/s_axis_tready | tuser: kind; tdata: first, second letter
// m_axis   | out | m_axis_tvalid/m_axis_tready | tuser: status; tdata: cipher first, second
//
// Key letters are placed as they are accepted. A key end sweeps the alphabet to fill the square,
// unless it is already complete. A letter pair passes position memory read, square memory read
// and output load in turn. Kind 3 and ignored key items are accepted and dropped.
// Reset clears the used flags, fill counter and output valid.
// A stalled result holds in the output register; the next key item still enters,
// a new item is held off while the sweep runs or while a pair is looked up or waits to load.

module playfair_digraph_encrypt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [4:0] first_letter, [9:5] second_letter, zero pad
    input  logic [1:0]  s_axis_tuser,   // [1:0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [4:0] cipher_first, [9:5] cipher_second, zero pad
    output logic [0:0]  m_axis_tuser    // [0] status
);

    pfenc_pkg::t_cmd    cmd;
    pfenc_pkg::t_stat   stat;
    pfenc_pkg::t_letter cipher_first;
    pfenc_pkg::t_letter cipher_second;
    logic               status;

    pfenc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_kind     (s_axis_tuser),
        .i_stat     (stat),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    pfenc_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_first         (s_axis_tdata[4:0]),
        .i_second        (s_axis_tdata[9:5]),
        .i_out_ready     (m_axis_tready),
        .o_stat          (stat),
        .o_out_valid     (m_axis_tvalid),
        .o_cipher_first  (cipher_first),
        .o_cipher_second (cipher_second),
        .o_status        (status)
    );

    assign m_axis_tdata = {6'd0, cipher_second, cipher_first};
    assign m_axis_tuser = status;

endmodule

// File: rtl/pfenc_ctrl.sv
// Controller state machine: sequences key placement, square fill and pair lookup.
`timescale 1ns / 1ps

module pfenc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [1:0]       i_kind,
    input  pfenc_pkg::t_stat i_stat,
    output logic             o_in_ready,
    output pfenc_pkg::t_cmd  o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_FILL = 2'd1;
    localparam logic [1:0] ST_SQR  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       accept;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (i_kind)
                        pfenc_pkg::KIND_KEY: begin
                            o_cmd.key_place = 1'b1;
                        end
                        pfenc_pkg::KIND_END: begin
                            if (!i_stat.complete) begin
                                o_cmd.fill_start = 1'b1;
                                n_state          = ST_FILL;
                            end
                        end
                        pfenc_pkg::KIND_PAIR: begin
                            o_cmd.pair_read = 1'b1;
                            n_state         = ST_SQR;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_FILL: begin
                o_cmd.fill_step = 1'b1;
                if (i_stat.fill_last) begin
                    o_cmd.set_complete = 1'b1;
                    n_state            = ST_IDLE;
                end
            end
            ST_SQR: begin
                o_cmd.sq_read = 1'b1;
                n_state       = ST_OUT;
            end
            ST_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: rtl/pfenc_dp.sv
// Datapath: key square memories, used flags, fill counter and output register.
`timescale 1ns / 1ps

module pfenc_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pfenc_pkg::t_cmd     i_cmd,
    input  pfenc_pkg::t_letter  i_first,
    input  pfenc_pkg::t_letter  i_second,
    input  logic                i_out_ready,
    output pfenc_pkg::t_stat    o_stat,
    output logic                o_out_valid,
    output pfenc_pkg::t_letter  o_cipher_first,
    output pfenc_pkg::t_letter  o_cipher_second,
    output logic                o_status
);

    localparam logic [4:0] LAST_LETTER = 5'(pfenc_pkg::LETTERS - 1);
    localparam logic [4:0] NUM_LETTERS = 5'(pfenc_pkg::LETTERS);
    localparam logic [4:0] NUM_CELLS   = 5'(pfenc_pkg::CELLS);

    // key square and letter position memories
    pfenc_pkg::t_letter sq_mem  [pfenc_pkg::CELLS];
    pfenc_pkg::t_cell   pos_mem [pfenc_pkg::LETTERS];

    logic [pfenc_pkg::LETTERS-1:0] r_used;
    pfenc_pkg::t_cell              r_fill;
    logic                          r_complete;
    pfenc_pkg::t_letter            r_sweep;

    pfenc_pkg::t_cell   r_pa;
    pfenc_pkg::t_cell   r_pb;
    logic               r_err;
    pfenc_pkg::t_letter r_x;
    pfenc_pkg::t_letter r_y;

    logic               r_out_valid;
    pfenc_pkg::t_letter r_cf;
    pfenc_pkg::t_letter r_cs;
    logic               r_st;

    logic               first_ok;
    logic               second_ok;
    logic               place_req;
    logic               place_en;
    pfenc_pkg::t_letter place_letter;
    pfenc_pkg::t_letter addr_a;
    pfenc_pkg::t_letter addr_b;
    pfenc_pkg::t_cell   pa;
    pfenc_pkg::t_cell   pb;
    pfenc_pkg::t_rc     r1;
    pfenc_pkg::t_rc     c1;
    pfenc_pkg::t_rc     r2;
    pfenc_pkg::t_rc     c2;
    pfenc_pkg::t_cell   xa;
    pfenc_pkg::t_cell   ya;

    assign first_ok  = (i_first  < NUM_LETTERS);
    assign second_ok = (i_second < NUM_LETTERS);

    // letter to place: key letter or the fill sweep
    always_comb begin
        if (i_cmd.key_place) begin
            place_letter = pfenc_pkg::fold_letter(i_first);
            place_req    = !r_complete && first_ok;
        end else begin
            place_letter = r_sweep;
            place_req    = i_cmd.fill_step && (r_sweep != pfenc_pkg::LETTER_J);
        end
        place_en = place_req && !r_used[place_letter] && (r_fill < NUM_CELLS);
    end

    // position lookup addresses, clamped for out-of-range letters
    assign addr_a = first_ok  ? pfenc_pkg::fold_letter(i_first)  : 5'd0;
    assign addr_b = second_ok ? pfenc_pkg::fold_letter(i_second) : 5'd0;

    // cipher cell addresses from the two positions
    always_comb begin
        pa = (r_pa < NUM_CELLS) ? r_pa : 5'd0;
        pb = (r_pb < NUM_CELLS) ? r_pb : 5'd0;
        r1 = pfenc_pkg::pos_row(pa);
        c1 = pfenc_pkg::pos_col(pa);
        r2 = pfenc_pkg::pos_row(pb);
        c2 = pfenc_pkg::pos_col(pb);
        priority if (r1 == r2) begin
            xa = pfenc_pkg::rc_index(r1, pfenc_pkg::next_rc(c1));
            ya = pfenc_pkg::rc_index(r2, pfenc_pkg::next_rc(c2));
        end else if (c1 == c2) begin
            xa = pfenc_pkg::rc_index(pfenc_pkg::next_rc(r1), c1);
            ya = pfenc_pkg::rc_index(pfenc_pkg::next_rc(r2), c2);
        end else begin
            xa = pfenc_pkg::rc_index(r1, c2);
            ya = pfenc_pkg::rc_index(r2, c1);
        end
    end

    // memory writes and registered reads
    always_ff @(posedge i_clk) begin
        if (place_en) begin
            sq_mem[r_fill]        <= place_letter;
            pos_mem[place_letter] <= r_fill;
        end
        if (i_cmd.pair_read) begin
            r_pa  <= pos_mem[addr_a];
            r_pb  <= pos_mem[addr_b];
            r_err <= !r_complete || !first_ok || !second_ok;
        end
        if (i_cmd.sq_read) begin
            r_x <= sq_mem[xa];
            r_y <= sq_mem[ya];
        end
    end

    // used flags, fill counter, sweep and completion
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used     <= '0;
            r_fill     <= '0;
            r_complete <= 1'b0;
            r_sweep    <= '0;
        end else begin
            if (place_en) begin
                r_used[place_letter] <= 1'b1;
                r_fill               <= r_fill + 5'd1;
            end
            if (i_cmd.fill_start) begin
                r_sweep <= '0;
            end else if (i_cmd.fill_step) begin
                r_sweep <= r_sweep + 5'd1;
            end
            if (i_cmd.set_complete) begin
                r_complete <= 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_cf <= r_err ? 5'd0 : r_x;
            r_cs <= r_err ? 5'd0 : r_y;
            r_st <= r_err ? pfenc_pkg::STATUS_ERR : pfenc_pkg::STATUS_OK;
        end
    end

    assign o_stat.complete  = r_complete;
    assign o_stat.fill_last = (r_sweep == LAST_LETTER);
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid     = r_out_valid;
    assign o_cipher_first  = r_cf;
    assign o_cipher_second = r_cs;
    assign o_status        = r_st;

endmodule

// File: rtl/pfenc_checker.sv
// Port-level checker for the Playfair digraph encryptor, bound to the top level.
`timescale 1ns / 1ps

module pfenc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [15:0] s_axis_tdata,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);

    // a stalled result beat holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result beat changed");

    // a pair beat keeps the input closed in the next cycle while it is looked up
    a_pair_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == pfenc_pkg::KIND_PAIR) |=>
            !s_axis_tready)
        else $error("input accepted during pair lookup");

    // a good result holds square letters: in range and never j
    a_ok_letters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser[0] == pfenc_pkg::STATUS_OK) |->
            (m_axis_tdata[4:0] < 5'd26) && (m_axis_tdata[9:5] < 5'd26) &&
            (m_axis_tdata[4:0] != pfenc_pkg::LETTER_J) &&
            (m_axis_tdata[9:5] != pfenc_pkg::LETTER_J))
        else $error("cipher letter outside the square");

    // an error result carries zero letters
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser[0] == pfenc_pkg::STATUS_ERR) |->
            (m_axis_tdata == 16'd0))
        else $error("error result with nonzero letters");

endmodule

bind playfair_digraph_encrypt pfenc_checker u_pfenc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
